[design/mbrptp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MBR partition table parser package
// Shared types, constants and the type-to-class lookup.
// ----------------------------------------------------------------------------
package mbrptp_pkg;

  localparam int unsigned SectorBytes = 512;
  localparam int unsigned TableBase   = 446;
  localparam int unsigned SigBase     = 510;
  localparam int unsigned NumSlots    = 4;
  localparam int unsigned SlotW       = 2;
  localparam int unsigned PosW        = 10;

  localparam logic [7:0] SigFirst  = 8'h55;
  localparam logic [7:0] SigSecond = 8'hAA;

  localparam logic [1:0] STATUS_RECORD    = 2'd0;
  localparam logic [1:0] STATUS_BAD_SIG   = 2'd1;
  localparam logic [1:0] STATUS_NO_PART   = 2'd2;
  localparam logic [1:0] STATUS_WRONG_LEN = 2'd3;

  localparam logic [2:0] FS_RAW    = 3'd0;
  localparam logic [2:0] FS_FAT    = 3'd1;
  localparam logic [2:0] FS_NTFS   = 3'd2;
  localparam logic [2:0] FS_LINUX  = 3'd3;
  localparam logic [2:0] FS_NATIVE = 3'd4;
  localparam logic [2:0] FS_GPT    = 3'd5;

  typedef struct packed {
    logic [7:0]  type_code;
    logic [31:0] start_block;
    logic [31:0] length_blocks;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic                valid;
    logic [1:0]          status;
    logic [NumSlots-1:0] mask;
  } sector_end_t;

  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] slot;
  } slot_pick_t;

  function automatic logic [2:0] class_of(input logic [7:0] t);
    logic [2:0] c;
    unique case (t)
      8'h01, 8'h04, 8'h06, 8'h0B, 8'h0C, 8'h0E: c = FS_FAT;
      8'h07:   c = FS_NTFS;
      8'h83:   c = FS_LINUX;
      8'h99:   c = FS_NATIVE;
      8'hEE:   c = FS_GPT;
      default: c = FS_RAW;
    endcase
    return c;
  endfunction

  // Lowest set bit of the mask at or above the start slot.
  function automatic slot_pick_t pick_slot(input logic [NumSlots-1:0] mask,
                                           input logic [SlotW:0] start);
    slot_pick_t p;
    p = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (mask[i] && (i >= int'(start))) begin
        p.found = 1'b1;
        p.slot  = SlotW'(i);
      end
    end
    return p;
  endfunction

endpackage
`default_nettype wire

[design/mbr_partition_table_parser_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MBR partition table parser
// Parses the first sector of a disk and reports its primary partitions.
// ----------------------------------------------------------------------------
// Sector bytes are taken one per cycle while s_tready is high. Each partition
// entry is assembled as it streams in and written to a four-word entry memory
// on its final byte. After the byte marked last, a sector with a bad length,
// a bad signature or no usable entries gives one status transfer; otherwise
// the emitter reads the memory once per qualifying slot, and each record
// passes a memory read state, then an output load state. The input is held off
// from the last byte until the final result of the sector has been transferred.
module mbr_partition_table_parser_unit
  import mbrptp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // data_byte
  input  wire logic        s_tlast,  // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [87:0] m_tdata,  // device_id, part_number, type_code,
                                     // fs_class, start_block, length_blocks
  output logic      [1:0]  m_tuser,  // status
  output logic             m_tlast,  // last_result
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [3:0]       source_device;
  logic             take;
  logic             wr_en;
  logic [SlotW-1:0] wr_addr;
  entry_t           wr_data;
  logic [SlotW-1:0] rd_addr;
  entry_t           rd_data;
  sector_end_t      sector_end;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {28'd0, source_device} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_device <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      source_device <= pwdata[3:0];
    end
  end

  assign take = s_tvalid && s_tready;

  mbrptp_collect u_collect (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .data_byte  (s_tdata),
    .last_byte  (s_tlast),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .sector_end (sector_end)
  );

  mbrptp_ram #(
    .WIDTH (EntryW),
    .DEPTH (NumSlots)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  logic emit_ready;

  mbrptp_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .source_device (source_device),
    .sector_end    (sector_end),
    .rd_data       (rd_data),
    .rd_addr       (rd_addr),
    .in_ready      (emit_ready),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast)
  );

  // Hold the input for the cycle in which a verdict is in flight.
  assign s_tready = emit_ready && !sector_end.valid;

endmodule
`default_nettype wire

[design/mbrptp_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mbrptp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[design/mbrptp_collect.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MBR sector collector
// Tracks the byte position, assembles each partition entry and writes it to
// the entry memory on its final byte, and judges the sector on its last byte.
// ----------------------------------------------------------------------------
module mbrptp_collect
  import mbrptp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  output logic                   wr_en,
  output logic      [SlotW-1:0]  wr_addr,
  output entry_t                 wr_data,
  output sector_end_t            sector_end
);

  logic [PosW-1:0]     pos;
  logic [7:0]          sig_hi;
  logic [NumSlots-1:0] mask;
  entry_t              asm_entry;
  entry_t              entry_next;

  logic [PosW-1:0] rel_full;
  logic [3:0]      off;
  logic            in_table;
  logic            length_ok;
  logic            sig_ok;

  assign in_table = (pos >= PosW'(TableBase)) && (pos < PosW'(SigBase));
  assign rel_full = pos - PosW'(TableBase);
  assign off      = rel_full[3:0];
  assign length_ok = (pos == PosW'(SectorBytes - 1));
  assign sig_ok    = (sig_hi == SigFirst) && (data_byte == SigSecond);

  always_comb begin
    entry_next = asm_entry;
    if (off == 4'd4) begin
      entry_next.type_code = data_byte;
    end else if (off >= 4'd8 && off < 4'd12) begin
      entry_next.start_block[off[1:0]*8 +: 8] = data_byte;
    end else if (off >= 4'd12) begin
      entry_next.length_blocks[off[1:0]*8 +: 8] = data_byte;
    end
  end

  assign wr_en   = take && in_table && (off == 4'd15);
  assign wr_addr = rel_full[5:4];
  assign wr_data = entry_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      mask       <= '0;
      sector_end <= '0;
    end else begin
      sector_end.valid <= 1'b0;
      if (take) begin
        if (!pos[PosW-1]) begin
          pos <= pos + PosW'(1);
        end
        if (wr_en) begin
          mask[wr_addr] <= (entry_next.type_code != 8'd0) &&
                           (entry_next.length_blocks != 32'd0);
        end
        if (last_byte) begin
          pos              <= '0;
          sector_end.valid <= 1'b1;
          sector_end.mask  <= mask;
          if (!length_ok) begin
            sector_end.status <= STATUS_WRONG_LEN;
          end else if (!sig_ok) begin
            sector_end.status <= STATUS_BAD_SIG;
          end else if (mask == '0) begin
            sector_end.status <= STATUS_NO_PART;
          end else begin
            sector_end.status <= STATUS_RECORD;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_table) begin
      asm_entry <= entry_next;
    end
    if (take && pos == PosW'(SigBase)) begin
      sig_hi <= data_byte;
    end
  end

endmodule
`default_nettype wire

[design/mbrptp_emit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MBR result emitter
// Turns a sector verdict into a status result or walks the entry memory over
// the qualifying slots, one record per read.
// ----------------------------------------------------------------------------
module mbrptp_emit
  import mbrptp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [3:0]        source_device,
  input  wire sector_end_t       sector_end,
  input  wire entry_t            rd_data,
  output logic      [SlotW-1:0]  rd_addr,
  output logic                   in_ready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [87:0]       m_tdata,  // device_id, part_number, type_code,
                                           // fs_class, start_block,
                                           // length_blocks, zero fill
  output logic      [1:0]        m_tuser,  // status
  output logic                   m_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0]          state;
  logic [SlotW-1:0]    slot;
  logic [NumSlots-1:0] mask;
  logic [3:0]          dev;
  logic                out_free;
  slot_pick_t          first_pick;
  slot_pick_t          next_pick;

  assign out_free   = !m_tvalid || m_tready;
  assign in_ready   = (state == ST_IDLE) && !m_tvalid;
  assign rd_addr    = slot;
  assign first_pick = pick_slot(sector_end.mask, '0);
  assign next_pick  = pick_slot(mask, {1'b0, slot} + (SlotW + 1)'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sector_end.valid) begin
            if (sector_end.status == STATUS_RECORD) begin
              state <= ST_READ;
            end else begin
              m_tvalid <= 1'b1;
            end
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= next_pick.found ? ST_READ : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && sector_end.valid) begin
      mask    <= sector_end.mask;
      dev     <= source_device;
      slot    <= first_pick.slot;
      m_tuser <= sector_end.status;
      m_tlast <= 1'b1;
      m_tdata <= {84'd0, source_device};
    end else if (state == ST_LOAD && out_free) begin
      m_tuser <= STATUS_RECORD;
      m_tlast <= !next_pick.found;
      m_tdata <= {6'd0, rd_data.length_blocks, rd_data.start_block,
                  class_of(rd_data.type_code), rd_data.type_code,
                  {1'b0, slot} + 3'd1, dev};
      if (next_pick.found) begin
        slot <= next_pick.slot;
      end
    end
  end

endmodule
`default_nettype wire

[sim/tb_mbr_partition_table_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MBR partition table parser testbench
// Streams whole and malformed sectors into the parser and checks every
// result transfer against a cycle-free model of the decode, or against the stated status of typed sectors.
// ----------------------------------------------------------------------------
module tb_mbr_partition_table_parser_unit
  import mbrptp_pkg::*;
();

  localparam logic [2:0] REG_SOURCE_DEVICE = 3'd0;
  localparam logic [2:0] REG_SPARE         = 3'd4;

  typedef struct packed {
    logic [3:0]  dev;
    logic [1:0]  status;
    logic [2:0]  part;
    logic [7:0]  ptype;
    logic [2:0]  fs;
    logic [31:0] start_blk;
    logic [31:0] len_blk;
    logic        last;
  } mbr_record_t;

  typedef struct packed {
    logic [10:0]      nbytes;
    logic             noisy;
    logic [7:0]       fill;
    logic [15:0]      sig;
    logic [3:0][7:0]  types;
    logic [3:0][31:0] starts;
    logic [3:0][31:0] lengths;
    logic [3:0]       dev;
    logic             typed;
    logic [1:0]       status;
  } sector_desc_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // data_byte
  logic        s_tlast;   // last_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [87:0] m_tdata;   // device_id, part_number, type_code, fs_class,
                          // start_block, length_blocks
  logic [1:0]  m_tuser;   // status
  logic        m_tlast;   // last_result
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mbr_partition_table_parser_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // Model state for the sector being parsed.
  logic [3:0]       cfg_dev;
  logic [9:0]       sect_pos;
  logic [3:0][7:0]  sect_type;
  logic [3:0][31:0] sect_start;
  logic [3:0][31:0] sect_len;
  logic [15:0]      sect_sig;

  mbr_record_t  sector_records[$];
  mbr_record_t  pending_records[$];
  sector_desc_t directed[$];
  int           records_queued;
  int           mismatches;
  int           send_idle_pct;
  int           rcv_idle_pct;
  logic         hold_req;
  int           hold_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [2:0] fs_of(input logic [7:0] t);
    case (t)
      8'h01, 8'h04, 8'h06, 8'h0B, 8'h0C, 8'h0E: return FS_FAT;
      8'h07: return FS_NTFS;
      8'h83: return FS_LINUX;
      8'h99: return FS_NATIVE;
      8'hEE: return FS_GPT;
      default: return FS_RAW;
    endcase
  endfunction

  task automatic parse_sector_byte(input logic [7:0] b, input logic lst);
    int unsigned rel;
    int unsigned off;
    int unsigned slot;
    logic        len_ok;
    mbr_record_t r;
    len_ok = (sect_pos == 10'(SectorBytes - 1));
    if (sect_pos < SectorBytes) begin
      if (sect_pos >= TableBase && sect_pos < SigBase) begin
        rel = sect_pos - TableBase;
        slot = rel / 16;
        off = rel % 16;
        if (off == 4) begin
          sect_type[slot] = b;
        end else if (off >= 8 && off < 12) begin
          sect_start[slot][(off - 8) * 8 +: 8] = b;
        end else if (off >= 12) begin
          sect_len[slot][(off - 12) * 8 +: 8] = b;
        end
      end else if (sect_pos == SigBase) begin
        sect_sig[15:8] = b;
      end else if (sect_pos == SigBase + 1) begin
        sect_sig[7:0] = b;
      end
      sect_pos = sect_pos + 10'd1;
    end
    if (lst) begin
      r = '0;
      r.dev = cfg_dev;
      r.last = 1'b1;
      if (!len_ok) begin
        r.status = STATUS_WRONG_LEN;
        sector_records.push_back(r);
      end else if (sect_sig != {SigFirst, SigSecond}) begin
        r.status = STATUS_BAD_SIG;
        sector_records.push_back(r);
      end else begin
        for (int i = 0; i < 4; i++) begin
          if (sect_type[i] != 8'd0 && sect_len[i] != 32'd0) begin
            r.status = STATUS_RECORD;
            r.part = 3'(i + 1);
            r.ptype = sect_type[i];
            r.fs = fs_of(sect_type[i]);
            r.start_blk = sect_start[i];
            r.len_blk = sect_len[i];
            r.last = 1'b0;
            sector_records.push_back(r);
          end
        end
        if (sector_records.size() == 0) begin
          r = '0;
          r.dev = cfg_dev;
          r.status = STATUS_NO_PART;
          r.last = 1'b1;
          sector_records.push_back(r);
        end else begin
          sector_records[sector_records.size() - 1].last = 1'b1;
        end
      end
      sect_pos = '0;
      sect_type = '0;
      sect_start = '0;
      sect_len = '0;
      sect_sig = '0;
    end
  endtask

  function automatic logic [7:0] sector_byte(input sector_desc_t s, input int unsigned pos);
    int unsigned rel;
    int unsigned off;
    logic [7:0]  b;
    b = s.noisy ? 8'($urandom) : s.fill;
    if (pos >= TableBase && pos < SigBase) begin
      rel = pos - TableBase;
      off = rel % 16;
      if (off == 4) begin
        b = s.types[rel / 16];
      end else if (off >= 8 && off < 12) begin
        b = s.starts[rel / 16][(off - 8) * 8 +: 8];
      end else if (off >= 12) begin
        b = s.lengths[rel / 16][(off - 12) * 8 +: 8];
      end
    end else if (pos == SigBase) begin
      b = s.sig[15:8];
    end else if (pos == SigBase + 1) begin
      b = s.sig[7:0];
    end
    return b;
  endfunction

  function automatic sector_desc_t mk_sector(input int n, input logic [7:0] fill,
                                             input logic [15:0] sig,
                                             input logic [3:0][7:0] types,
                                             input logic [3:0][31:0] starts,
                                             input logic [3:0][31:0] lengths,
                                             input logic [3:0] dev, input logic typed,
                                             input logic [1:0] status);
    sector_desc_t s;
    s = '0;
    s.nbytes = 11'(n);
    s.fill = fill;
    s.sig = sig;
    s.types = types;
    s.starts = starts;
    s.lengths = lengths;
    s.dev = dev;
    s.typed = typed;
    s.status = status;
    return s;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(1, 255));
      default: return $urandom;
    endcase
  endfunction

  function automatic sector_desc_t random_sector();
    logic [7:0]   known [11] = '{8'h01, 8'h04, 8'h06, 8'h0B, 8'h0C, 8'h0E,
                                 8'h07, 8'h83, 8'h99, 8'hEE, 8'h00};
    sector_desc_t s;
    int           k;
    s = '0;
    s.noisy = 1'b1;
    k = $urandom_range(99);
    if (k < 78) begin
      s.nbytes = 11'd512;
    end else if (k < 86) begin
      s.nbytes = ($urandom_range(1) == 0) ? 11'd511 : 11'($urandom_range(1, 510));
    end else if (k < 96) begin
      s.nbytes = 11'($urandom_range(513, 540));
    end else begin
      s.nbytes = 11'($urandom_range(1000, 1100));
    end
    k = $urandom_range(99);
    if (k < 85) begin
      s.sig = {SigFirst, SigSecond};
    end else if (k < 93) begin
      s.sig = {SigFirst, SigSecond} ^ (16'd1 << $urandom_range(15));
    end else begin
      s.sig = 16'($urandom);
    end
    for (int i = 0; i < 4; i++) begin
      k = $urandom_range(17);
      s.types[i] = (k < 11) ? known[k] : ((k < 13) ? 8'h00 : 8'($urandom));
      s.starts[i] = rand_word();
      s.lengths[i] = rand_word();
    end
    return s;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= lst;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    parse_sector_byte(b, lst);
  endtask

  task automatic send_sector(input sector_desc_t s);
    mbr_record_t r;
    for (int unsigned p = 0; p < s.nbytes; p++) begin
      push_byte(sector_byte(s, p), p == s.nbytes - 1);
    end
    if (s.typed) begin
      r = '0;
      r.dev = cfg_dev;
      r.status = s.status;
      r.last = 1'b1;
      pending_records.push_back(r);
      records_queued++;
    end else begin
      foreach (sector_records[i]) pending_records.push_back(sector_records[i]);
      records_queued += sector_records.size();
    end
    sector_records.delete();
  endtask

  // Stops offering bytes and lets the parser finish the sector in flight.
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == REG_SOURCE_DEVICE) cfg_dev = val[3:0];
    @(posedge clk);
  endtask

  task automatic set_device(input logic [3:0] dev);
    reg_write(REG_SOURCE_DEVICE, {28'($urandom), dev});
    reg_write(REG_SPARE, $urandom);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_SOURCE_DEVICE;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata !== 32'(cfg_dev)) begin
      $display("%0t: source_device read mismatch: expected %0h, actual %0h",
               $time, 32'(cfg_dev), prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    mbr_record_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected result transfer: expected none, actual %h/%h/%b",
                 $time, m_tdata, m_tuser, m_tlast);
        mismatches++;
      end else begin
        want = pending_records.pop_front();
        check_field("device_id", 32'(want.dev), 32'(m_tdata[3:0]));
        check_field("part_number", 32'(want.part), 32'(m_tdata[6:4]));
        check_field("type_code", 32'(want.ptype), 32'(m_tdata[14:7]));
        check_field("fs_class", 32'(want.fs), 32'(m_tdata[17:15]));
        check_field("start_block", want.start_blk, m_tdata[49:18]);
        check_field("length_blocks", want.len_blk, m_tdata[81:50]);
        check_field("pad", 32'd0, 32'(m_tdata[87:82]));
        check_field("status", 32'(want.status), 32'(m_tuser));
        check_field("last_result", 32'(want.last), 32'(m_tlast));
      end
    end
  end

  initial begin
    m_tready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int          sectors;
    int          k;
    logic [15:0] good_sig;
    good_sig = {SigFirst, SigSecond};
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    hold_req = 1'b0;
    send_idle_pct = 38;
    rcv_idle_pct = 38;
    mismatches = 0;
    records_queued = 0;
    cfg_dev = '0;
    sect_pos = '0;
    sect_type = '0;
    sect_start = '0;
    sect_len = '0;
    sect_sig = '0;

    // Slot 4 is the leftmost element of each packed list.
    directed.push_back(mk_sector(1, 8'hFF, 16'h0, '0, '0, '0, 4'd0, 1'b1, STATUS_WRONG_LEN));
    directed.push_back(mk_sector(511, 8'h00, good_sig, {8'h83, 8'h07, 8'h0C, 8'hEE},
                                 {4{32'h1234_5678}}, {4{32'h10}}, 4'd0, 1'b1,
                                 STATUS_WRONG_LEN));
    directed.push_back(mk_sector(512, 8'hFF, good_sig, '0, '0, '0, 4'd0, 1'b1,
                                 STATUS_NO_PART));
    directed.push_back(mk_sector(512, 8'h00, 16'hAA55, {8'h83, 8'h07, 8'h0C, 8'hEE},
                                 {4{32'h800}}, {4{32'h1000}}, 4'd0, 1'b1, STATUS_BAD_SIG));
    directed.push_back(mk_sector(513, 8'h00, good_sig, {8'h83, 8'h07, 8'h0C, 8'hEE},
                                 {4{32'h800}}, {4{32'h1000}}, 4'd0, 1'b1,
                                 STATUS_WRONG_LEN));
    directed.push_back(mk_sector(512, 8'h00, good_sig, {8'hEE, 8'h99, 8'h83, 8'h07},
                                 {32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd0},
                                 {32'd1, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF},
                                 4'd15, 1'b0, STATUS_RECORD));
    directed.push_back(mk_sector(512, 8'hFF, good_sig, {8'h0B, 8'h06, 8'h04, 8'h01},
                                 {32'hFFFF_FFFF, 32'h0000_003F, 32'h0001_0000, 32'd2048},
                                 {32'h00FF_00FF, 32'hFF00_FF00, 32'd2, 32'hFFFF_FFFF},
                                 4'd15, 1'b0, STATUS_RECORD));
    directed.push_back(mk_sector(512, 8'h00, good_sig, {8'hFF, 8'h00, 8'h0E, 8'h0C},
                                 {32'd7, 32'd6, 32'd5, 32'd4},
                                 {32'd0, 32'd5, 32'd9, 32'd8},
                                 4'd15, 1'b0, STATUS_RECORD));
    directed.push_back(mk_sector(512, 8'hFF, good_sig, {8'h05, 8'h00, 8'h00, 8'h00},
                                 {32'hDEAD_BEEF, 32'd0, 32'd0, 32'd0},
                                 {32'd7, 32'd1, 32'd1, 32'd1},
                                 4'd9, 1'b0, STATUS_RECORD));
    directed.push_back(mk_sector(512, 8'h00, 16'h55AB, {4{8'h83}}, {4{32'd1}}, {4{32'd1}},
                                 4'd9, 1'b1, STATUS_BAD_SIG));
    directed.push_back(mk_sector(512, 8'h00, 16'hD5AA, {4{8'h83}}, {4{32'd1}}, {4{32'd1}},
                                 4'd9, 1'b1, STATUS_BAD_SIG));
    directed.push_back(mk_sector(2, 8'hFF, 16'h0, '0, '0, '0, 4'd9, 1'b1,
                                 STATUS_WRONG_LEN));
    directed.push_back(mk_sector(700, 8'hFF, good_sig, {4{8'h07}}, {4{32'd3}}, {4{32'd3}},
                                 4'd0, 1'b1, STATUS_WRONG_LEN));
    directed.push_back(mk_sector(512, 8'hFF, good_sig, {8'hEE, 8'h99, 8'h83, 8'h07},
                                 {4{32'hFFFF_FFFF}}, '0, 4'd0, 1'b1, STATUS_NO_PART));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].dev != cfg_dev) begin
        settle_idle();
        set_device(directed[i].dev);
      end
      send_sector(directed[i]);
    end

    // Back-to-back traffic on both sides.
    settle_idle();
    send_idle_pct = 0;
    rcv_idle_pct = 0;
    repeat (2) send_sector(random_sector());
    send_idle_pct = 38;
    rcv_idle_pct = 38;

    // The receiver stalls while short sectors keep arriving.
    hold_req = 1'b1;
    repeat (6) begin
      send_sector(mk_sector($urandom_range(1, 3), 8'($urandom), 16'h0, '0, '0, '0,
                            cfg_dev, 1'b0, STATUS_WRONG_LEN));
    end
    settle_idle();

    sectors = 0;
    while (records_queued < 110) begin
      if (sectors % 6 == 0) begin
        settle_idle();
        k = $urandom_range(3);
        set_device((k == 0) ? 4'd0 : ((k == 1) ? 4'd15 : 4'($urandom)));
      end
      send_sector(random_sector());
      sectors++;
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/mbrptp_pkg.sv
design/mbrptp_ram.sv
design/mbrptp_collect.sv
design/mbrptp_emit.sv
design/mbr_partition_table_parser_unit.sv
sim/tb_mbr_partition_table_parser_unit.sv
